>>> rtl/core/mbap_pkg.sv
// Package with the shared types and constants of the MBAP deframer.
package mbap_pkg;

  localparam int unsigned HdrLen    = 6;
  localparam int unsigned LenMin    = 2;
  localparam int unsigned LenMax    = 254;
  localparam int unsigned QueueDepth = 7;

  localparam logic [15:0] AgeMax        = 16'hFFFF;
  localparam logic [15:0] TimeoutReset  = 16'd1000;
  localparam logic [8:0]  MaxFrameReset = 9'd260;

  localparam logic [1:0] OpByte  = 2'd0;
  localparam logic [1:0] OpTick  = 2'd1;
  localparam logic [1:0] OpClose = 2'd2;
  localparam logic [1:0] OpError = 2'd3;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadHeader = 3'd1;
  localparam logic [2:0] StTooLarge  = 3'd2;
  localparam logic [2:0] StTimeout   = 3'd3;
  localparam logic [2:0] StClean     = 3'd4;
  localparam logic [2:0] StMidFrame  = 3'd5;
  localparam logic [2:0] StTransport = 3'd6;
  localparam logic [2:0] StFailed    = 3'd7;

  localparam logic RegTimeout  = 1'b0;
  localparam logic RegMaxFrame = 1'b1;

  // One queued result: a single word, or a burst of the six header bytes.
  typedef struct packed {
    logic        burst;
    logic [7:0]  data_byte;
    logic        last;
    logic [2:0]  status;
    logic [47:0] hdr;
  } desc_t;

endpackage

>>> rtl/core/mbap_in_if.sv
// Input channel carrying stream events.
interface mbap_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

>>> rtl/core/mbap_out_if.sv
// Output channel carrying frame bytes and status words.
interface mbap_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic [2:0] status;

  modport source (output valid, output data_byte, output last, output status, input ready);
  modport sink (input valid, input data_byte, input last, input status, output ready);
endinterface

>>> rtl/core/mbap_core.sv
// Frame state, header check and result decode for each accepted event.
module mbap_core import mbap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] timeout_i,
  input  logic [8:0]  max_frame_i,
  output logic        push_o,
  output desc_t       desc_o
);

  logic [7:0]  hdr_q [HdrLen];
  logic [8:0]  taken_q, taken_d;
  logic [8:0]  target_q, target_d;
  logic [15:0] age_q, age_d;
  logic        failed_q, failed_d;
  logic        hdr_we;
  logic [15:0] age_inc;
  logic [8:0]  taken_inc;
  logic [15:0] frame_len;
  logic [8:0]  target_w;
  logic        hdr_bad;

  assign age_inc   = (age_q < AgeMax) ? age_q + 16'd1 : age_q;
  assign taken_inc = taken_q + 9'd1;
  assign frame_len = {hdr_q[4], rx_byte_i};
  assign target_w  = 9'(HdrLen) + 9'(rx_byte_i);
  assign hdr_bad   = (hdr_q[2] != 8'd0) || (hdr_q[3] != 8'd0) ||
                     (frame_len < 16'(LenMin)) || (frame_len > 16'(LenMax));

  always_comb begin
    taken_d  = taken_q;
    target_d = target_q;
    age_d    = age_q;
    failed_d = failed_q;
    hdr_we   = 1'b0;
    push_o   = 1'b0;
    desc_o   = '0;
    if (accept_i) begin
      if (failed_q) begin
        push_o        = 1'b1;
        desc_o.last   = 1'b1;
        desc_o.status = StFailed;
      end else begin
        case (operation_i)
          OpError: begin
            push_o        = 1'b1;
            failed_d      = 1'b1;
            desc_o.last   = 1'b1;
            desc_o.status = StTransport;
          end
          OpClose: begin
            push_o        = 1'b1;
            failed_d      = 1'b1;
            desc_o.last   = 1'b1;
            desc_o.status = (taken_q == 9'd0) ? StClean : StMidFrame;
          end
          OpTick: begin
            if (taken_q != 9'd0) begin
              age_d = age_inc;
              if (age_inc >= timeout_i) begin
                push_o        = 1'b1;
                failed_d      = 1'b1;
                desc_o.last   = 1'b1;
                desc_o.status = StTimeout;
              end
            end
          end
          OpByte: begin
            if (taken_q == 9'd0) begin
              age_d = '0;
            end
            if (taken_q < 9'(HdrLen)) begin
              hdr_we  = 1'b1;
              taken_d = taken_inc;
              if (taken_inc == 9'(HdrLen)) begin
                if (hdr_bad) begin
                  push_o        = 1'b1;
                  failed_d      = 1'b1;
                  desc_o.last   = 1'b1;
                  desc_o.status = StBadHeader;
                end else begin
                  target_d = target_w;
                  push_o   = 1'b1;
                  if (target_w > max_frame_i) begin
                    failed_d      = 1'b1;
                    desc_o.last   = 1'b1;
                    desc_o.status = StTooLarge;
                  end else begin
                    desc_o.burst = 1'b1;
                    desc_o.hdr   = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3], hdr_q[4],
                                    rx_byte_i};
                  end
                end
              end
            end else begin
              push_o           = 1'b1;
              desc_o.data_byte = rx_byte_i;
              if (taken_inc >= target_q) begin
                desc_o.last = 1'b1;
                taken_d     = '0;
                target_d    = 9'(HdrLen);
                age_d       = '0;
              end else begin
                taken_d = taken_inc;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q  <= '0;
      target_q <= 9'(HdrLen);
      age_q    <= '0;
      failed_q <= 1'b0;
    end else begin
      taken_q  <= taken_d;
      target_q <= target_d;
      age_q    <= age_d;
      failed_q <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[taken_q[2:0]] <= rx_byte_i;
    end
  end

`ifndef ASSERT_OFF
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> failed_q) else $error("failure latch cleared");
  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !failed_q |-> (taken_q <= target_q) && (target_q <= 9'(HdrLen + LenMax)))
    else $error("byte count beyond frame");
`endif

endmodule

>>> rtl/core/mbap_fifo.sv
// Small queue of result descriptors between the decode and the output stage.
module mbap_fifo import mbap_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output desc_t desc_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  desc_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign desc_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");
`endif

endmodule

>>> rtl/core/mbap_burst.sv
// Output register that expands header bursts into six words.
module mbap_burst import mbap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  desc_t       q_desc_i,
  output logic        pop_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [2:0]  status_o
);

  logic        out_valid_q;
  logic [7:0]  data_q;
  logic        last_q;
  logic [2:0]  status_q;
  logic [47:0] hdr_q;
  logic [2:0]  idx_q;
  logic        bursting_q;
  logic        can_load;
  logic [7:0]  hdr_byte;

  always_comb begin
    case (idx_q)
      3'd1:    hdr_byte = hdr_q[39:32];
      3'd2:    hdr_byte = hdr_q[31:24];
      3'd3:    hdr_byte = hdr_q[23:16];
      3'd4:    hdr_byte = hdr_q[15:8];
      3'd5:    hdr_byte = hdr_q[7:0];
      default: hdr_byte = hdr_q[47:40];
    endcase
  end

  assign can_load = !out_valid_q || out_ready_i;
  assign pop_o    = can_load && !bursting_q && q_valid_i;

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bursting_q  <= 1'b0;
      idx_q       <= '0;
    end else if (can_load) begin
      if (bursting_q) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 3'd1;
        if (idx_q == 3'(HdrLen - 1)) begin
          bursting_q <= 1'b0;
        end
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        bursting_q  <= q_desc_i.burst;
        idx_q       <= 3'd1;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load) begin
      if (bursting_q) begin
        data_q   <= hdr_byte;
        last_q   <= 1'b0;
        status_q <= StOk;
      end else if (q_valid_i) begin
        hdr_q <= q_desc_i.hdr;
        if (q_desc_i.burst) begin
          data_q   <= q_desc_i.hdr[47:40];
          last_q   <= 1'b0;
          status_q <= StOk;
        end else begin
          data_q   <= q_desc_i.data_byte;
          last_q   <= q_desc_i.last;
          status_q <= q_desc_i.status;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_burst_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bursting_q |-> out_valid_q && !last_q) else $error("header burst without word");
  a_burst_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bursting_q |-> idx_q >= 3'd1 && idx_q <= 3'(HdrLen - 1)) else $error("burst index");
`endif

endmodule

>>> rtl/core/mbap_frame_deframer.sv
// Modbus/TCP MBAP deframer top level: register port, decode, queue and output stage.
// The block accepts one stream event per cycle while ready is high; results pass the queue
// and a registered output stage, one word per cycle while out ready is high. A valid
// header releases its six bytes as six consecutive words, so the output stage briefly
// runs behind the input; a seven-entry result queue absorbs this, and the input drops
// ready only while that queue is full, which happens under output back-pressure.
// Configuration registers: 0x0 frame_timeout_ticks (16 bits), 0x4 max_frame_bytes (9 bits).
module mbap_frame_deframer import mbap_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mbap_in_if.sink     in_s,
  mbap_out_if.source  out_m
);

  logic [15:0] timeout_q;
  logic [8:0]  max_frame_q;
  logic        cfg_we;
  logic        accept;
  logic        push;
  desc_t       push_desc;
  logic        q_full;
  logic        q_valid;
  desc_t       q_desc;
  logic        pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegMaxFrame) ? {23'd0, max_frame_q} : {16'd0, timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TimeoutReset;
      max_frame_q <= MaxFrameReset;
    end else if (cfg_we) begin
      if (paddr[2] == RegTimeout) begin
        timeout_q <= pwdata[15:0];
      end else begin
        max_frame_q <= pwdata[8:0];
      end
    end
  end

  assign in_s.ready = !q_full;
  assign accept     = in_s.valid && !q_full;

  mbap_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (in_s.operation),
    .rx_byte_i   (in_s.rx_byte),
    .timeout_i   (timeout_q),
    .max_frame_i (max_frame_q),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  mbap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .desc_o  (q_desc)
  );

  mbap_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (q_desc),
    .pop_o       (pop),
    .out_ready_i (out_m.ready),
    .out_valid_o (out_m.valid),
    .data_byte_o (out_m.data_byte),
    .last_o      (out_m.last),
    .status_o    (out_m.status)
  );

endmodule

>>> test/mbap_frame_deframer_tb.sv
// Self-checking testbench for the MBAP deframer: stimulus, register writes and scoreboard.
`timescale 1ns / 1ps

module mbap_frame_deframer_tb import mbap_pkg::*; ;

  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 10;
  localparam int StallLimit  = 1000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic [2:0] status;
  } word_t;

  class mbap_frame_scoreboard;
    logic [7:0]  hdr[HdrLen];
    int unsigned taken;
    int unsigned target;
    logic [15:0] age;
    bit          failed;
    logic [15:0] timeout_ticks;
    logic [8:0]  max_frame;
    word_t       expected_words[$];
    int          errors;

    function new();
      foreach (hdr[i]) hdr[i] = '0;
      taken         = 0;
      target        = HdrLen;
      age           = '0;
      failed        = 0;
      timeout_ticks = TimeoutReset;
      max_frame     = MaxFrameReset;
      errors        = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == RegTimeout) begin
        timeout_ticks = value[15:0];
      end else begin
        max_frame = value[8:0];
      end
    endfunction

    function void push(logic [7:0] data_byte, logic last, logic [2:0] status);
      word_t w;
      w.data_byte = data_byte;
      w.last      = last;
      w.status    = status;
      expected_words.push_back(w);
    endfunction

    function void fail(logic [2:0] status);
      failed = 1;
      push(8'h00, 1'b1, status);
    endfunction

    function void note_event(logic [1:0] op, logic [7:0] b);
      logic [15:0] len;
      if (failed) begin
        push(8'h00, 1'b1, StFailed);
        return;
      end
      case (op)
        OpError: begin
          fail(StTransport);
        end
        OpClose: begin
          fail(taken == 0 ? StClean : StMidFrame);
        end
        OpTick: begin
          if (taken != 0) begin
            if (age != AgeMax) age++;
            if (age >= timeout_ticks) fail(StTimeout);
          end
        end
        default: begin
          if (taken == 0) age = '0;
          if (taken < HdrLen) begin
            hdr[taken] = b;
            taken++;
            if (taken < HdrLen) return;
            len = {hdr[4], hdr[5]};
            if (hdr[2] != 0 || hdr[3] != 0 || len < LenMin || len > LenMax) begin
              fail(StBadHeader);
              return;
            end
            target = HdrLen + len;
            if (target > max_frame) begin
              fail(StTooLarge);
              return;
            end
            for (int i = 0; i < HdrLen; i++) push(hdr[i], 1'b0, StOk);
          end else begin
            taken++;
            if (taken >= target) begin
              push(b, 1'b1, StOk);
              taken  = 0;
              target = HdrLen;
              age    = '0;
            end else begin
              push(b, 1'b0, StOk);
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(word_t got);
      word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word data=%02h last=%0b status=%0d",
                         got.data_byte, got.last, got.status));
        return;
      end
      want = expected_words.pop_front();
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte got %02h expected %02h", got.data_byte, want.data_byte));
      if (got.last !== want.last)
        report($sformatf("last got %0b expected %0b", got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("status got %0d expected %0d", got.status, want.status));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbap_in_if  in_ch ();
  mbap_out_if out_ch ();

  mbap_frame_deframer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_s    (in_ch),
    .out_m   (out_ch)
  );

  mbap_frame_scoreboard sb;
  int  cur_timeout;
  int  cur_max;
  bit  no_gaps;
  bit  hold_req;
  bit  hold_done;
  bit  pause_done;
  int  body_count;
  int  stall_cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else begin
        out_ch.ready = no_gaps || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.data_byte, out_ch.last, out_ch.status});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_event(input logic [1:0] op, input logic [7:0] b);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(0, 99) < 32) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.rx_byte   = b;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_event(op, b);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    logic [31:0] junk;
    junk = $urandom;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    psel        = 1'b1;
    penable     = 1'b0;
    pwrite      = 1'b1;
    paddr       = {idx, 2'b00};
    pwdata      = (idx == RegTimeout) ? {junk[31:16], value} : {junk[31:9], value[8:0]};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, pwdata);
    if (idx == RegTimeout) cur_timeout = value;
    else cur_max = value[8:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Sends the first count bytes of a frame, with ticks scattered inside it.
  task automatic send_frame(input logic [15:0] len, input int count, input int max_ticks,
                            input logic [15:0] proto);
    int ticks;
    logic [7:0] b;
    ticks = 0;
    for (int i = 0; i < count; i++) begin
      if (i > 0 && ticks < max_ticks && $urandom_range(0, 99) < 15) begin
        send_event(OpTick, 8'($urandom));
        ticks++;
      end
      if (i < 2) b = 8'($urandom);
      else if (i == 2) b = proto[15:8];
      else if (i == 3) b = proto[7:0];
      else if (i == 4) b = len[15:8];
      else if (i == 5) b = len[7:0];
      else b = 8'($urandom);
      send_event(OpByte, b);
    end
  endtask

  function automatic int pick_len();
    int lmax;
    lmax = cur_max - HdrLen;
    if (lmax > LenMax) lmax = LenMax;
    if (lmax < 13 || $urandom_range(0, 99) < 85)
      return $urandom_range(LenMin, lmax < 12 ? lmax : 12);
    return $urandom_range(13, lmax < 40 ? lmax : 40);
  endfunction

  function automatic int tick_budget();
    return (cur_timeout - 1 < 3) ? cur_timeout - 1 : 3;
  endfunction

  task automatic random_frames(input int goal);
    int len;
    while (body_count < goal) begin
      if ($urandom_range(0, 99) < 30) send_event(OpTick, 8'($urandom));
      len = pick_len();
      send_frame(16'(len), HdrLen + len, tick_budget(), 16'h0000);
      body_count += HdrLen + len;
      if (!hold_done && body_count >= 10) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && body_count >= 40) begin
        drain();
        pause_done = 1'b1;
      end
    end
  endtask

  // Ends the stream with one randomly chosen failure; later events all see the latch.
  task automatic finish_with_failure();
    int kind;
    int len;
    kind = $urandom_range(0, 7);
    case (kind)
      0: send_frame(16'(pick_len()), HdrLen, 0, 16'($urandom_range(1, 65535)));
      1: send_frame(16'($urandom_range(0, 1)), HdrLen, 0, 16'h0000);
      2: send_frame(16'($urandom_range(255, 65535)), HdrLen, 0, 16'h0000);
      3: begin
        drain();
        write_reg(RegMaxFrame, 16'($urandom_range(8, 259)));
        send_frame(16'($urandom_range(cur_max - 5, LenMax)), HdrLen, 0, 16'h0000);
      end
      4: begin
        drain();
        write_reg(RegTimeout, 16'($urandom_range(1, 4)));
        len = pick_len();
        send_frame(16'(len), $urandom_range(1, HdrLen - 1 + len), 0, 16'h0000);
        repeat (cur_timeout) send_event(OpTick, 8'($urandom));
      end
      5: begin
        send_event(OpTick, 8'($urandom));
        send_event(OpClose, 8'($urandom));
      end
      6: begin
        len = pick_len();
        send_frame(16'(len), $urandom_range(1, HdrLen - 1 + len), 0, 16'h0000);
        send_event(OpClose, 8'($urandom));
      end
      default: begin
        len = pick_len();
        send_frame(16'(len), $urandom_range(0, HdrLen - 1 + len), 0, 16'h0000);
        send_event(OpError, 8'($urandom));
      end
    endcase
    repeat (12) send_event(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  initial begin
    sb              = new();
    cur_timeout     = TimeoutReset;
    cur_max         = MaxFrameReset;
    no_gaps         = 1'b0;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    pause_done      = 1'b0;
    body_count      = 0;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OpByte;
    in_ch.rx_byte   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: a shortest frame, then a frame of length three, ticks outside and inside a frame.
    send_event(OpTick, 8'hFF);
    send_event(OpByte, 8'hFF);
    send_event(OpByte, 8'hFF);
    send_event(OpByte, 8'h00);
    send_event(OpByte, 8'h00);
    send_event(OpTick, 8'h00);
    send_event(OpByte, 8'h00);
    send_event(OpByte, 8'h02);
    send_event(OpByte, 8'hFF);
    send_event(OpTick, 8'hFF);
    send_event(OpByte, 8'h00);
    send_event(OpByte, 8'h5A);
    send_event(OpByte, 8'hA5);
    send_event(OpByte, 8'h00);
    send_event(OpByte, 8'h00);
    send_event(OpByte, 8'h00);
    send_event(OpByte, 8'h03);
    send_event(OpByte, 8'h80);
    send_event(OpByte, 8'h7F);
    send_event(OpByte, 8'h01);

    // Tightest settings: a frame that exactly fills the capacity.
    drain();
    write_reg(RegTimeout, 16'd1);
    write_reg(RegMaxFrame, 16'd8);
    send_event(OpTick, 8'hAA);
    send_frame(16'd2, 8, 0, 16'h0000);

    // Loosest settings: a long frame back to back, then random traffic.
    drain();
    write_reg(RegTimeout, 16'hFFFF);
    write_reg(RegMaxFrame, 16'd260);
    no_gaps = 1'b1;
    send_frame(16'd40, 46, 3, 16'h0000);
    no_gaps = 1'b0;
    random_frames(30);

    drain();
    write_reg(RegTimeout, 16'($urandom_range(2, 65535)));
    write_reg(RegMaxFrame, 16'($urandom_range(8, 260)));
    random_frames(60);

    finish_with_failure();
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
